>>> rtl/core/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int TAG_W        = 16;
  localparam int PRIO_W       = 32;
  localparam int COUNT_W      = 5;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REM_HEAD = 2'd1,
    OP_REM_TAG  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TAG_W-1:0]  entry_tag;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TAG_W-1:0]   out_tag;
    logic [PRIO_W-1:0]  out_priority;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic add;
    logic rem;
  } cell_ctl_t;

endpackage

>>> rtl/core/sorted_priority_queue.sv
// sorted priority queue: the response is registered and goes valid in the cycle after the request transfer
// throughput one operation per cycle, limited only by the response register
// every accepted add or remove that succeeds updates the affected cells of the chain together
// reset clears the count, the cell valid bits and the response valid flag
// slot payloads are not reset and are only visible once written
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                accept;
  logic                full;
  logic                found;
  cell_ctl_t           ctl;
  entry_t              new_entry;
  entry_t              cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_mark;
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] match_pre;
  logic [CAPACITY-1:0] take_right;
  rsp_t                rsp_next;
  logic [CNT_W+4:0]    count_ext;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign found     = |cell_match;
  assign new_entry = '{tag: req.entry_tag, prio: req.priority_req};

  // prefix or: cells at or after the first tag hit close the gap
  always_comb begin
    match_pre = cell_match;
    for (int s = 1; s < CAPACITY; s = s * 2) begin
      match_pre = match_pre | (match_pre << s);
    end
  end

  always_comb begin
    ctl        = '0;
    take_right = match_pre;
    count_next = count;
    rsp_next   = '0;
    rsp_next.status = ST_OK;
    unique case (req.operation)
      OP_ADD: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          ctl.add    = accept;
          count_next = count + 1'b1;
        end
      end
      OP_REM_HEAD: begin
        take_right = '1;
        if (count == '0) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          ctl.rem               = accept;
          count_next            = count - 1'b1;
          rsp_next.out_tag      = cell_entry[0].tag;
          rsp_next.out_priority = cell_entry[0].prio;
        end
      end
      OP_REM_TAG: begin
        if (found) begin
          ctl.rem    = accept;
          count_next = count - 1'b1;
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      default: begin
        // unused code: no change
      end
    endcase
    count_ext            = {5'b0, count_next};
    rsp_next.entry_count = count_ext[4:0];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_mark;
    entry_t left_entry;
    logic   left_valid;
    entry_t right_entry;
    logic   right_valid;

    if (i == 0) begin : g_first
      assign left_mark  = 1'b0;
      assign left_entry = '0;
      assign left_valid = 1'b0;
    end else begin : g_inner_l
      assign left_mark  = cell_mark[i-1];
      assign left_entry = cell_entry[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_r
      assign right_entry = cell_entry[i+1];
      assign right_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_mark   (left_mark),
      .left_entry  (left_entry),
      .left_valid  (left_valid),
      .take_right  (take_right[i]),
      .right_entry (right_entry),
      .right_valid (right_valid),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .mark        (cell_mark[i]),
      .match       (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // checks
  logic [CAPACITY-1:0] therm;
  logic [CAPACITY-1:0] order_ok;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      therm[i] = (($clog2(CAPACITY) + 1)'(i) < ($clog2(CAPACITY) + 1)'(count));
    end
    order_ok[0] = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      order_ok[i] = !cell_valid[i] || (cell_entry[i-1].prio <= cell_entry[i].prio);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    cell_valid == therm)
    else $error("cell valid bits disagree with count");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    &order_ok)
    else $error("queue entries out of priority order");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    accept && req.operation == OP_ADD && !full |=> count == $past(count) + 1'b1)
    else $error("accepted add did not grow the queue");

endmodule

>>> rtl/core/spq_cell.sv
// one slot of the queue chain: holds an entry and shifts with its neighbors
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_entry,
  input  logic               left_mark,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_valid,
  input  logic               take_right,
  input  spq_pkg::entry_t    right_entry,
  input  logic               right_valid,
  output spq_pkg::entry_t    entry,
  output logic               valid,
  output logic               mark,
  output logic               match
);
  import spq_pkg::*;

  // mark: new entry goes at or before this slot
  assign mark  = !valid || (entry.prio > new_entry.prio);
  assign match = valid && (entry.tag == new_entry.tag);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.add) begin
      if (left_mark) begin
        valid <= left_valid;
      end else if (mark) begin
        valid <= 1'b1;
      end
    end else if (ctl.rem && take_right) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add) begin
      if (left_mark) begin
        entry <= left_entry;
      end else if (mark) begin
        entry <= new_entry;
      end
    end else if (ctl.rem && take_right) begin
      entry <= right_entry;
    end
  end

endmodule
